### rtl/cfe_pkg.sv
// Shared types and constants of the chunked frame encoder.
package cfe_pkg;

   localparam int unsigned DATA_W   = 8;
   localparam int unsigned TOTAL_W  = 24;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned RUN_MAX  = 7;
   localparam int unsigned RUN_CNT_W = 3;

   localparam logic [DATA_W-1:0] FRAME_HEADER = 8'h89;
   localparam logic [DATA_W-1:0] CHECK_OFFSET = 8'h07;

   // Request codes carried in req_type.
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_COMMAND = 1'b0;
   localparam logic CSR_TOTAL   = 1'b1;

   // One byte of the framed stream as produced by the frame builder.
   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              frame_end;
      logic              overrun;
   } result_type;

   // All results caused by one request, entry 0 goes out first.
   typedef struct packed {
      result_type [RUN_MAX-1:0] entry;
      logic [RUN_CNT_W-1:0]     count;
   } run_type;

endpackage

### rtl/cfe_req_if.sv
// Request channel of the chunked frame encoder.
interface cfe_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

### rtl/cfe_rsp_if.sv
// Response channel of the chunked frame encoder.
interface cfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       last_of_run;
   logic       overrun;

   modport source (output valid, output out_byte, output frame_end, output last_of_run,
                   output overrun, input ready);
   modport sink (input valid, input out_byte, input frame_end, input last_of_run,
                 input overrun, output ready);
endinterface

### rtl/chunked_frame_encoder.sv
// Top level of the chunked frame encoder: configuration registers and channel handshakes.
//
// The encoder cuts a transfer of total_length payload bytes into frames of at most
// MAX_CHUNK payload bytes. Each frame is sent as header 0x89, command_code, the
// little-endian 16-bit length (chunk bytes plus one), a continue byte, the chunk bytes
// and a checksum that is the XOR of all earlier frame bytes plus 7. A request with
// req_type 0 starts a transfer and yields the first header (a whole six-byte frame when
// total_length is zero); a request with req_type 1 carries one payload byte, which is
// passed through and, at the end of a chunk, followed by the checksum and the next
// header. A byte that arrives with no frame open is dropped and answered with a single
// response flagged overrun. One request produces one to seven responses, one per clock
// unless the receiver stalls; last_of_run marks the final one. The frame builder settles
// all responses of a request in the cycle it is accepted and parks them in a run buffer;
// the next request is taken in the same cycle that the last buffered response moves to
// the output register, so payload bytes flow at one per clock unless the receiver stalls.
// A response waiting in the output register does not block the next request as long as
// the run buffer is empty. Both configuration registers are read live and should be
// written only while the encoder is idle.
module chunked_frame_encoder #(
   parameter int unsigned MAX_CHUNK = 2047
) (
   input  logic                        clock,
   input  logic                        reset,
   cfe_req_if.sink                     req_ch,
   cfe_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [cfe_pkg::TOTAL_W-1:0] csr_wr_data
);

   logic [cfe_pkg::DATA_W-1:0]  command_code_ff;
   logic [cfe_pkg::TOTAL_W-1:0] total_length_ff;

   logic                accept;
   logic                load_ready;
   cfe_pkg::run_type    run;
   cfe_pkg::result_type out_result;
   logic                out_last;
   logic                out_valid;

   // Configuration writes take effect at the clock edge where the enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         command_code_ff <= '0;
         total_length_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cfe_pkg::CSR_COMMAND: command_code_ff <= csr_wr_data[cfe_pkg::DATA_W-1:0];
            cfe_pkg::CSR_TOTAL:   total_length_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // A request transfer happens whenever the run buffer can take a new run.
   assign req_ch.ready = load_ready;
   assign accept       = req_ch.valid && load_ready;

   cfe_frame_builder #(
      .MAX_CHUNK(MAX_CHUNK)
   ) u_builder (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_type     (req_ch.req_type),
      .data_byte    (req_ch.data_byte),
      .command_code (command_code_ff),
      .total_length (total_length_ff),
      .run          (run)
   );

   cfe_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .run        (run),
      .load_ready (load_ready),
      .out_ready  (rsp_ch.ready),
      .out_valid  (out_valid),
      .out_result (out_result),
      .out_last   (out_last)
   );

   // The response channel is driven straight from the output register.
   assign rsp_ch.valid       = out_valid;
   assign rsp_ch.out_byte    = out_result.out_byte;
   assign rsp_ch.frame_end   = out_result.frame_end;
   assign rsp_ch.overrun     = out_result.overrun;
   assign rsp_ch.last_of_run = out_last;

endmodule

### rtl/cfe_frame_builder.sv
// Frame state and the run of output bytes that one request produces.
module cfe_frame_builder #(
   parameter int unsigned MAX_CHUNK = 2047
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic                            req_type,
   input  logic [cfe_pkg::DATA_W-1:0]      data_byte,
   input  logic [cfe_pkg::DATA_W-1:0]      command_code,
   input  logic [cfe_pkg::TOTAL_W-1:0]     total_length,
   output cfe_pkg::run_type                run
);

   localparam int unsigned CHUNK_W = $clog2(MAX_CHUNK + 1);
   localparam logic [cfe_pkg::TOTAL_W-1:0] MaxChunkTotal = cfe_pkg::TOTAL_W'(MAX_CHUNK);
   localparam logic [CHUNK_W-1:0]          MaxChunkCnt   = CHUNK_W'(MAX_CHUNK);

   logic [cfe_pkg::TOTAL_W-1:0] bytes_sent_ff, bytes_sent_in;
   logic [CHUNK_W-1:0]          chunk_rem_ff, chunk_rem_in;
   logic [cfe_pkg::DATA_W-1:0]  run_xor_ff, run_xor_in;
   logic                        more_ff, more_in;

   logic [cfe_pkg::TOTAL_W-1:0] bytes_inc;
   logic [cfe_pkg::TOTAL_W-1:0] base;
   logic [cfe_pkg::TOTAL_W:0]   diff;
   logic [cfe_pkg::TOTAL_W-1:0] rem;
   logic                        cont;
   logic [CHUNK_W-1:0]          chunk;
   logic [cfe_pkg::LEN_W-1:0]   len;
   logic [cfe_pkg::DATA_W-1:0]  hdr_xor;
   logic [cfe_pkg::DATA_W-1:0]  byte_xor;
   logic [CHUNK_W-1:0]          rem_dec;
   cfe_pkg::result_type [4:0]   hdr;

   // Frame opening logic, shared by a start and by a chunk that closes.
   always_comb begin
      bytes_inc = bytes_sent_ff + cfe_pkg::TOTAL_W'(1);
      base      = (req_type == cfe_pkg::REQ_DATA) ? bytes_inc : '0;
      diff      = {1'b0, total_length} - {1'b0, base};
      rem       = diff[cfe_pkg::TOTAL_W] ? '0 : diff[cfe_pkg::TOTAL_W-1:0];
      cont      = rem > MaxChunkTotal;
      chunk     = cont ? MaxChunkCnt : rem[CHUNK_W-1:0];
      len       = cfe_pkg::LEN_W'(chunk) + cfe_pkg::LEN_W'(1);
      hdr_xor   = cfe_pkg::FRAME_HEADER ^ command_code ^ len[7:0] ^ len[15:8]
                  ^ {7'b0, cont};
      hdr[0]    = '{out_byte: cfe_pkg::FRAME_HEADER, frame_end: 1'b0, overrun: 1'b0};
      hdr[1]    = '{out_byte: command_code, frame_end: 1'b0, overrun: 1'b0};
      hdr[2]    = '{out_byte: len[7:0], frame_end: 1'b0, overrun: 1'b0};
      hdr[3]    = '{out_byte: len[15:8], frame_end: 1'b0, overrun: 1'b0};
      hdr[4]    = '{out_byte: {7'b0, cont}, frame_end: 1'b0, overrun: 1'b0};
      byte_xor  = run_xor_ff ^ data_byte;
      rem_dec   = chunk_rem_ff - CHUNK_W'(1);
   end

   always_comb begin
      run           = '0;
      bytes_sent_in = bytes_sent_ff;
      chunk_rem_in  = chunk_rem_ff;
      run_xor_in    = run_xor_ff;
      more_in       = more_ff;
      if (req_type == cfe_pkg::REQ_START) begin
         for (int i = 0; i < 5; i++) begin
            run.entry[i] = hdr[i];
         end
         bytes_sent_in = '0;
         chunk_rem_in  = chunk;
         run_xor_in    = hdr_xor;
         more_in       = cont;
         if (chunk == '0) begin
            run.entry[5] = '{out_byte: hdr_xor + cfe_pkg::CHECK_OFFSET,
                             frame_end: 1'b1, overrun: 1'b0};
            run.count    = cfe_pkg::RUN_CNT_W'(6);
         end else begin
            run.count    = cfe_pkg::RUN_CNT_W'(5);
         end
      end else if (chunk_rem_ff == '0) begin
         // No frame is open: the byte is dropped and flagged.
         run.entry[0] = '{out_byte: '0, frame_end: 1'b0, overrun: 1'b1};
         run.count    = cfe_pkg::RUN_CNT_W'(1);
      end else begin
         run.entry[0]  = '{out_byte: data_byte, frame_end: 1'b0, overrun: 1'b0};
         bytes_sent_in = bytes_inc;
         run_xor_in    = byte_xor;
         chunk_rem_in  = rem_dec;
         run.count     = cfe_pkg::RUN_CNT_W'(1);
         if (rem_dec == '0) begin
            run.entry[1] = '{out_byte: byte_xor + cfe_pkg::CHECK_OFFSET,
                             frame_end: 1'b1, overrun: 1'b0};
            if (more_ff && rem != '0) begin
               for (int i = 0; i < 5; i++) begin
                  run.entry[i+2] = hdr[i];
               end
               run.count    = cfe_pkg::RUN_CNT_W'(7);
               chunk_rem_in = chunk;
               run_xor_in   = hdr_xor;
               more_in      = cont;
            end else begin
               run.count = cfe_pkg::RUN_CNT_W'(2);
               more_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_sent_ff <= '0;
         chunk_rem_ff  <= '0;
         run_xor_ff    <= '0;
         more_ff       <= 1'b0;
      end else if (accept) begin
         bytes_sent_ff <= bytes_sent_in;
         chunk_rem_ff  <= chunk_rem_in;
         run_xor_ff    <= run_xor_in;
         more_ff       <= more_in;
      end
   end

endmodule

### rtl/cfe_serializer.sv
// Run buffer that hands out one framed byte per transfer through an output register.
module cfe_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  cfe_pkg::run_type    run,
   output logic                load_ready,
   input  logic                out_ready,
   output logic                out_valid,
   output cfe_pkg::result_type out_result,
   output logic                out_last
);

   cfe_pkg::result_type [cfe_pkg::RUN_MAX-1:0] entry_ff, entry_in;
   logic [cfe_pkg::RUN_CNT_W-1:0]              count_ff, count_in;
   logic                                       out_valid_ff, out_valid_in;
   cfe_pkg::result_type                        out_ff, out_in;
   logic                                       last_ff, last_in;
   logic                                       pop;

   always_comb begin
      pop          = (count_ff != '0) && (!out_valid_ff || out_ready);
      load_ready   = (count_ff == '0) || (pop && count_ff == cfe_pkg::RUN_CNT_W'(1));
      entry_in     = entry_ff;
      count_in     = count_ff;
      out_in       = out_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (pop) begin
         out_in       = entry_ff[0];
         last_in      = (count_ff == cfe_pkg::RUN_CNT_W'(1));
         out_valid_in = 1'b1;
         for (int i = 0; i < cfe_pkg::RUN_MAX - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         entry_in[cfe_pkg::RUN_MAX-1] = '0;
         count_in = count_ff - cfe_pkg::RUN_CNT_W'(1);
      end
      if (load) begin
         entry_in = run.entry;
         count_in = run.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      out_ff   <= out_in;
      last_ff  <= last_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign out_last   = last_ff;

endmodule

### sim/tb_chunked_frame_encoder.sv
// Self-checking testbench of the chunked frame encoder with a byte-stream scoreboard.
`timescale 1ns / 100ps

module tb_chunked_frame_encoder;

   // The encoder runs at its default chunk size. All transfers that are fed to the end stay
   // far below it; the largest total opens a full-size chunk, so the continue byte and a
   // non-zero high length byte are seen before that transfer is abandoned.
   localparam int unsigned MAX_CHUNK = 2047;
   localparam int unsigned PHASE_ITEMS = 30;

   // One byte of the framed stream together with its flags.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       last_of_run;
      logic       overrun;
   } frame_byte_type;

   // Scoreboard: it predicts the framed stream from each accepted request and checks every
   // accepted response against the oldest predicted byte.
   class frame_stream_checker;
      frame_byte_type expected_bytes[$];
      frame_byte_type run[$];
      logic [7:0]  command_code;
      logic [23:0] total_length;
      logic [23:0] bytes_taken;
      logic [11:0] chunk_left;
      logic [7:0]  frame_xor;
      logic        more_follows;
      int          failures;

      function new();
         command_code = '0;
         total_length = '0;
         bytes_taken  = '0;
         chunk_left   = '0;
         frame_xor    = '0;
         more_follows = 1'b0;
         failures     = 0;
      endfunction

      function void write_register(logic index, logic [23:0] value);
         if (index == cfe_pkg::CSR_COMMAND) begin
            command_code = value[7:0];
         end else begin
            total_length = value;
         end
      endfunction

      function void add_result(logic [7:0] value, logic closes, logic dropped);
         frame_byte_type item;
         item.out_byte    = value;
         item.frame_end   = closes;
         item.last_of_run = 1'b0;
         item.overrun     = dropped;
         run.push_back(item);
      endfunction

      function void add_frame_byte(logic [7:0] value);
         frame_xor = frame_xor ^ value;
         add_result(value, 1'b0, 1'b0);
      endfunction

      function void add_checksum();
         add_result(frame_xor + cfe_pkg::CHECK_OFFSET, 1'b1, 1'b0);
      endfunction

      // Emits a header for the next chunk, sized from what is left of the transfer.
      function void open_frame();
         logic [23:0] left;
         logic [11:0] chunk;
         logic [15:0] frame_len;
         logic        cont;
         left      = (total_length > bytes_taken) ? total_length - bytes_taken : 24'd0;
         chunk     = (left > MAX_CHUNK) ? 12'(MAX_CHUNK) : left[11:0];
         frame_len = 16'(chunk) + 16'd1;
         cont      = ({1'b0, bytes_taken} + 25'(chunk)) < {1'b0, total_length};
         frame_xor = '0;
         add_frame_byte(cfe_pkg::FRAME_HEADER);
         add_frame_byte(command_code);
         add_frame_byte(frame_len[7:0]);
         add_frame_byte(frame_len[15:8]);
         add_frame_byte({7'd0, cont});
         chunk_left   = chunk;
         more_follows = cont;
         if (chunk == 0) begin
            add_checksum();
         end
      endfunction

      function void note_request(logic kind, logic [7:0] value);
         run.delete();
         if (kind == cfe_pkg::REQ_START) begin
            bytes_taken = '0;
            open_frame();
         end else if (chunk_left == 0) begin
            add_result(8'd0, 1'b0, 1'b1);
         end else begin
            add_frame_byte(value);
            chunk_left  = chunk_left - 12'd1;
            bytes_taken = bytes_taken + 24'd1;
            if (chunk_left == 0) begin
               add_checksum();
               if (more_follows && total_length > bytes_taken) begin
                  open_frame();
               end else begin
                  more_follows = 1'b0;
               end
            end
         end
         run[run.size() - 1].last_of_run = 1'b1;
         foreach (run[i]) begin
            expected_bytes.push_back(run[i]);
         end
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      function void check_byte(frame_byte_type seen);
         frame_byte_type want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h end %0b last %0b overrun %0b",
                             seen.out_byte, seen.frame_end, seen.last_of_run, seen.overrun));
            return;
         end
         want = expected_bytes.pop_front();
         if (seen !== want) begin
            report($sformatf({"expected byte %02h end %0b last %0b overrun %0b, ",
                              "got %02h %0b %0b %0b"},
                             want.out_byte, want.frame_end, want.last_of_run, want.overrun,
                             seen.out_byte, seen.frame_end, seen.last_of_run, seen.overrun));
         end
      endfunction

      function void check_leftover();
         if (expected_bytes.size() != 0) begin
            report($sformatf("%0d predicted bytes never came out", expected_bytes.size()));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [23:0] csr_wr_data;

   cfe_req_if req_if ();
   cfe_rsp_if rsp_if ();

   frame_stream_checker frames;

   // Idle rates in percent of cycles for the request and the response side.
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;

   chunked_frame_encoder #(
      .MAX_CHUNK(MAX_CHUNK)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // Presents one request, idling at random beforehand, and returns at the edge where
   // the transfer happens. The valid stays high on return so that back-to-back requests
   // go out without a bubble; the drain wait lowers it, as does the next call when it idles.
   task automatic send_request(logic kind, logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.req_type  <= kind;
      req_if.data_byte <= value;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      frames.note_request(kind, value);
      items_sent++;
   endtask

   // Holds the request side quiet until every predicted byte has been taken.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (frames.expected_bytes.size() != 0);
   endtask

   // Rewrites both registers once the encoder has nothing in flight. Every request causes
   // at least one response, so an empty scoreboard means the encoder is idle.
   task automatic set_registers(logic [7:0] command, logic [23:0] total);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_index   <= cfe_pkg::CSR_COMMAND;
      csr_wr_data <= {16'd0, command};
      @(posedge clock);
      frames.write_register(cfe_pkg::CSR_COMMAND, {16'd0, command});
      csr_index   <= cfe_pkg::CSR_TOTAL;
      csr_wr_data <= total;
      @(posedge clock);
      frames.write_register(cfe_pkg::CSR_TOTAL, total);
      csr_wr_en <= 1'b0;
   endtask

   // One random scenario: mostly a well-formed transfer with random payload, at times cut
   // short by a new start, fed past its end, or given new register values half way; the
   // rest is loose noise on whatever transfer is open.
   task automatic random_scenario();
      int unsigned pick;
      int unsigned total;
      int unsigned count;
      pick = $urandom_range(99);
      if (pick < 20) begin
         repeat ($urandom_range(1, 4)) begin
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end else begin
         pick = $urandom_range(9);
         if (pick < 6) begin
            total = $urandom_range(0, 8);
         end else if (pick < 8) begin
            total = $urandom_range(9, 30);
         end else begin
            total = $urandom & 32'h00FF_FFFF;
         end
         set_registers(8'($urandom_range(255)), 24'(total));
         send_request(cfe_pkg::REQ_START, 8'($urandom_range(255)));
         // A huge transfer is fed only one to six bytes and then abandoned by the next start.
         count = (total > 30) ? $urandom_range(1, 6) : total;
         for (int unsigned i = 0; i < count; i++) begin
            if (i > 0 && $urandom_range(19) == 0) begin
               set_registers(8'($urandom_range(255)), 24'($urandom_range(0, total + 2)));
            end
            if ($urandom_range(29) == 0) begin
               send_request(cfe_pkg::REQ_START, 8'($urandom_range(255)));
            end
            send_request(cfe_pkg::REQ_DATA, 8'($urandom_range(255)));
         end
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
               send_request(cfe_pkg::REQ_DATA, 8'($urandom_range(255)));
            end
         end
      end
   endtask

   // Response side: checks every transfer and then draws the ready for the next cycle.
   initial begin
      frame_byte_type seen;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            seen.out_byte    = rsp_if.out_byte;
            seen.frame_end   = rsp_if.frame_end;
            seen.last_of_run = rsp_if.last_of_run;
            seen.overrun     = rsp_if.overrun;
            frames.check_byte(seen);
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Main sequence.
   initial begin
      frames = new();
      send_idle_pct = 19;
      recv_idle_pct = 63;
      items_sent    = 0;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.req_type  <= cfe_pkg::REQ_START;
      req_if.data_byte <= 8'd0;
      csr_wr_en        <= 1'b0;
      csr_index        <= cfe_pkg::CSR_COMMAND;
      csr_wr_data      <= 24'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty transfer: a start with zero total gives a complete six-byte frame, and a
      // byte that follows finds no frame open and is dropped.
      set_registers(8'h00, 24'd0);
      send_request(cfe_pkg::REQ_START, 8'h00);
      send_request(cfe_pkg::REQ_DATA, 8'hFF);

      // Short transfer with the extreme payload values, closed by its checksum, then
      // one byte past the end.
      set_registers(8'hFF, 24'd3);
      send_request(cfe_pkg::REQ_START, 8'hFF);
      send_request(cfe_pkg::REQ_DATA, 8'h00);
      send_request(cfe_pkg::REQ_DATA, 8'hFF);
      send_request(cfe_pkg::REQ_DATA, 8'h5A);
      send_request(cfe_pkg::REQ_DATA, 8'hA5);

      // Largest total: a full-size first chunk with the continue byte set, abandoned
      // part way by a second start.
      set_registers(8'hA5, 24'hFF_FFFF);
      send_request(cfe_pkg::REQ_START, 8'h3C);
      send_request(cfe_pkg::REQ_DATA, 8'h01);
      send_request(cfe_pkg::REQ_DATA, 8'h80);
      send_request(cfe_pkg::REQ_START, 8'hC3);
      send_request(cfe_pkg::REQ_DATA, 8'h7F);

      // One-byte transfer followed by a dropped byte.
      set_registers(8'h3C, 24'd1);
      send_request(cfe_pkg::REQ_START, 8'h00);
      send_request(cfe_pkg::REQ_DATA, 8'h7E);
      send_request(cfe_pkg::REQ_DATA, 8'h81);

      // Random part under three idle patterns: the sender idles lightly while the
      // receiver stalls hard, then the reverse, then both run flat out.
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 63;
            recv_idle_pct = 19;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            random_scenario();
         end
      end

      // Let the last run drain, then give the encoder a few more cycles in which any
      // stray response would be flagged.
      wait_drained();
      repeat (20) @(posedge clock);
      frames.check_leftover();
      if (frames.failures == 0) begin
         $display("PASS chunked_frame_encoder");
      end else begin
         $display("FAIL chunked_frame_encoder");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("FAIL chunked_frame_encoder");
      $finish;
   end

endmodule

### sim.f
rtl/cfe_pkg.sv
rtl/cfe_req_if.sv
rtl/cfe_rsp_if.sv
rtl/cfe_frame_builder.sv
rtl/cfe_serializer.sv
rtl/chunked_frame_encoder.sv
sim/tb_chunked_frame_encoder.sv
